/* sv/assert_macros.svh */
// Concurrent assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

/* sv/pgu_pkg.sv */
package pgu_pkg;

  localparam int LANES               = 4;
  localparam int LANE_W              = 2;
  localparam int CODE_W              = 2;
  localparam int INDEX_W             = 12;
  localparam int ROW_W               = 12;
  localparam int VALUE_W             = 16;
  localparam int COLUMN_W            = 16;
  localparam int SAMPLE_CNT_W        = 13;
  localparam int CODE_TABLE_W        = 64;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 64;
  localparam int DEFAULT_MAX_SAMPLES = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_VARIANTS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_TABLE     = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic             en;
    logic             keep;
    logic [ROW_W-1:0] row;
  } mem_wr_t;

  typedef struct packed {
    logic                      hit;
    logic [ROW_W-1:0]          row;
    logic signed [VALUE_W-1:0] value;
  } lane_out_t;

endpackage

/* sv/pgu_lane.sv */
module pgu_lane import pgu_pkg::*; #(
  parameter int BANK_DEPTH = DEFAULT_MAX_SAMPLES / LANES,
  parameter int BANK_AW    = 10
) (
  input  logic                    clk,
  input  mem_wr_t                 wr,
  input  logic [BANK_AW-1:0]      wr_addr,
  input  logic                    rd_en,
  input  logic [BANK_AW-1:0]      rd_addr,
  input  logic                    rd_active,
  input  logic [CODE_W-1:0]       rd_code,
  input  logic [CODE_TABLE_W-1:0] code_table,
  output lane_out_t               lane
);

  logic [ROW_W:0]      mem [BANK_DEPTH];
  logic [ROW_W:0]      rd_word;
  logic                active;
  logic [CODE_W-1:0]   code;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.keep, wr.row};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
      active  <= rd_active;
      code    <= rd_code;
    end
  end

  always_comb begin
    lane.hit   = active & rd_word[ROW_W];
    lane.row   = rd_word[ROW_W-1:0];
    lane.value = $signed(code_table[{code, 4'b0000} +: VALUE_W]);
  end

endmodule

/* sv/pgu_merge.sv */
module pgu_merge import pgu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  lane_out_t                 lanes [LANES],
  input  logic [COLUMN_W-1:0]       load_column,
  input  logic                      out_stall,
  output logic                      free,
  output logic                      out_valid,
  output logic [COLUMN_W-1:0]       column,
  output logic [ROW_W-1:0]          row,
  output logic signed [VALUE_W-1:0] value,
  output logic                      last
);

  logic [LANES-1:0]    pending;
  logic [LANES-1:0]    pending_next;
  logic [LANES-1:0]    hits;
  logic [LANES-1:0]    rest;
  lane_out_t           slot [LANES];
  logic [COLUMN_W-1:0] col_reg;
  logic [LANE_W-1:0]   sel;
  logic                xfer;

  always_comb begin
    sel = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (pending[k]) begin
        sel = LANE_W'(k);
      end
    end
    for (int k = 0; k < LANES; k++) begin
      hits[k] = lanes[k].hit;
    end
    out_valid = |pending;
    xfer      = out_valid && !out_stall;
    rest      = pending & (pending - 1'b1);
    last      = (rest == '0);
    free      = (pending == '0) || (xfer && last);
    column    = col_reg;
    row       = slot[sel].row;
    value     = slot[sel].value;
    if (load) begin
      pending_next = hits;
    end else if (xfer) begin
      pending_next = rest;
    end else begin
      pending_next = pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_reg <= load_column;
      for (int k = 0; k < LANES; k++) begin
        slot[k] <= lanes[k];
      end
    end
  end

endmodule

/* sv/packed_genotype_unpacker_unit.sv */
// Packed 2-bit genotype unpacker.
// Input channel (in_valid/in_stall): op 0 writes the remap entry at map_index
// (keep bit and target row); op 1 delivers one packed byte of four genotype
// codes, low pair first, for the next four file samples of the current variant.
// Output channel (out_valid/out_stall): one transaction per kept sample with
// column, row, signed Q8.8 value, and last marking the final result of a byte.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sample_count,
// 1 chunk_variants, 2 code_table; write only while the block is idle.
// The lane stage registers each byte's codes and remap entries; the merge stage
// loads them once free. A new byte is accepted while older results drain; the
// four lanes read their remap banks in parallel and the merge stage emits one
// result per cycle while the receiver does not stall.
// While the receiver stalls, the current result holds; one more byte is
// absorbed in the lane stage, then in_stall rises.
// Reset clears byte position, column, pending results and registers
// (sample_count 1, chunk_variants 1, code_table 0); remap entries stay
// undefined until loaded.
module packed_genotype_unpacker_unit import pgu_pkg::*; #(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [INDEX_W-1:0]        map_index,
  input  logic                      map_keep,
  input  logic [ROW_W-1:0]          map_row,
  input  logic [7:0]                data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COLUMN_W-1:0]       column,
  output logic [ROW_W-1:0]          row,
  output logic signed [VALUE_W-1:0] value,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int BANK_DEPTH = (MAX_SAMPLES + LANES - 1) / LANES;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int NW         = $clog2(MAX_SAMPLES + 1);
  localparam int NW1        = NW + 1;
  localparam int SW         = NW + 2;

  logic [SAMPLE_CNT_W-1:0] sample_count;
  logic [COLUMN_W-1:0]     chunk_variants;
  logic [CODE_TABLE_W-1:0] code_table;
  logic [BANK_AW-1:0]      byte_position;
  logic [COLUMN_W-1:0]     column_counter;
  logic                    s1_valid;
  logic [COLUMN_W-1:0]     s1_column;

  logic [NW-1:0]           eff_n;
  logic [NW1-1:0]          bytes_per_variant;
  logic [NW1-1:0]          bp_inc;
  logic                    variant_end;
  logic [COLUMN_W:0]       col_inc;
  logic [COLUMN_W:0]       col_limit;
  logic                    col_wrap;
  logic [SW-1:0]           base;
  logic                    in_xfer;
  logic                    data_xfer;
  logic                    load_xfer;
  logic                    merge_free;
  logic                    s1_move;
  logic                    index_ok;
  logic [BANK_AW-1:0]      wr_addr;
  lane_out_t               lanes [LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= SAMPLE_CNT_W'(1);
      chunk_variants <= COLUMN_W'(1);
      code_table     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_COUNT:   sample_count   <= cfg_data[SAMPLE_CNT_W-1:0];
        REG_CHUNK_VARIANTS: chunk_variants <= cfg_data[COLUMN_W-1:0];
        REG_CODE_TABLE:     code_table     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_count == '0) begin
      eff_n = NW'(1);
    end else if (32'(sample_count) > MAX_SAMPLES) begin
      eff_n = NW'(MAX_SAMPLES);
    end else begin
      eff_n = NW'(sample_count);
    end
    bytes_per_variant = (NW1'(eff_n) + NW1'(3)) >> 2;
    bp_inc            = NW1'(byte_position) + NW1'(1);
    variant_end       = bp_inc >= bytes_per_variant;
    col_inc           = {1'b0, column_counter} + 1'b1;
    col_limit         = (chunk_variants == '0) ? {1'b1, {COLUMN_W{1'b0}}}
                                               : {1'b0, chunk_variants};
    col_wrap          = col_inc >= col_limit;
    base              = SW'(byte_position) << 2;
  end

  assign in_xfer   = in_valid && !in_stall;
  assign data_xfer = in_xfer && (op == OP_DATA);
  assign load_xfer = in_xfer && (op == OP_LOAD);
  assign s1_move   = s1_valid && merge_free;
  assign in_stall  = s1_valid && !merge_free;
  assign index_ok  = 32'(map_index) < MAX_SAMPLES;
  assign wr_addr   = BANK_AW'(map_index >> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      column_counter <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (data_xfer) begin
        if (variant_end) begin
          byte_position  <= '0;
          column_counter <= col_wrap ? '0 : col_inc[COLUMN_W-1:0];
        end else begin
          byte_position <= BANK_AW'(bp_inc);
        end
      end
      if (data_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_xfer) begin
      s1_column <= column_counter;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mem_wr_t lane_wr;

    always_comb begin
      lane_wr.en   = load_xfer && index_ok && (map_index[LANE_W-1:0] == LANE_W'(k));
      lane_wr.keep = map_keep;
      lane_wr.row  = map_row;
    end

    pgu_lane #(
      .BANK_DEPTH (BANK_DEPTH),
      .BANK_AW    (BANK_AW)
    ) u_lane (
      .clk        (clk),
      .wr         (lane_wr),
      .wr_addr    (wr_addr),
      .rd_en      (data_xfer),
      .rd_addr    (byte_position),
      .rd_active  ((base + SW'(k)) < SW'(eff_n)),
      .rd_code    (data_byte[CODE_W*k +: CODE_W]),
      .code_table (code_table),
      .lane       (lanes[k])
    );
  end

  pgu_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_move),
    .lanes       (lanes),
    .load_column (s1_column),
    .out_stall   (out_stall),
    .free        (merge_free),
    .out_valid   (out_valid),
    .column      (column),
    .row         (row),
    .value       (value),
    .last        (last)
  );

endmodule

/* sv/pgu_checker.sv */
`include "assert_macros.svh"

module pgu_checker import pgu_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [COLUMN_W-1:0]       column,
  input logic [ROW_W-1:0]          row,
  input logic signed [VALUE_W-1:0] value,
  input logic                      last
);

  logic [COLUMN_W+ROW_W+VALUE_W:0] payload;
  logic                            mid;

  assign payload = {column, row, value, last};
  assign mid     = out_valid && !out_stall && !last;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(payload))
  `ASSERT_IMPLIES(a_stall_backed, clk, rst, in_valid && in_stall, out_valid)
  `ASSERT_NEXT(a_more_follows, clk, rst, mid, out_valid)
  `ASSERT_IMPLIES(a_four_max, clk, rst, mid && $past(mid) && $past(mid, 2), !$past(mid, 3))

endmodule

bind packed_genotype_unpacker_unit pgu_checker u_pgu_checker (.*);

/* tb/tb_top.sv */
module tb_top import pgu_pkg::*; ();

  localparam int LIMIT_CYCLES = 300000;
  localparam int ITEM_TARGET  = 110;
  localparam int DRAIN        = 12;
  localparam int SQUEEZE_LEN  = 150;

  typedef struct {
    bit [COLUMN_W-1:0]        column;
    bit [ROW_W-1:0]           row;
    bit signed [VALUE_W-1:0]  value;
    bit                       last;
  } call_t;

  class call_board_t;
    bit [SAMPLE_CNT_W-1:0]   sample_cnt = 1;
    bit [COLUMN_W-1:0]       chunk_len = 1;
    bit [CODE_TABLE_W-1:0]   code_tbl = '0;
    int unsigned             byte_pos = 0;
    int unsigned             col_ctr = 0;
    bit                      keep_mem [DEFAULT_MAX_SAMPLES];
    bit [ROW_W-1:0]          row_mem [DEFAULT_MAX_SAMPLES];
    bit                      written [DEFAULT_MAX_SAMPLES];
    call_t                   calls_due[$];
    int                      errors = 0;
    int                      bytes_seen = 0;
    int                      loads_seen = 0;
    int                      calls_matched = 0;

    function int unsigned eff_samples();
      int unsigned n;
      n = sample_cnt;
      if (n == 0) n = 1;
      if (n > DEFAULT_MAX_SAMPLES) n = DEFAULT_MAX_SAMPLES;
      return n;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SAMPLE_COUNT: sample_cnt = data[SAMPLE_CNT_W-1:0];
        REG_CHUNK_VARIANTS: chunk_len = data[COLUMN_W-1:0];
        REG_CODE_TABLE: code_tbl = data;
        default: ;
      endcase
    endfunction

    function void accept_item(logic op_v, logic [INDEX_W-1:0] idx, logic keep_v,
                              logic [ROW_W-1:0] row_v, logic [7:0] b);
      int unsigned n;
      int unsigned bpv;
      int unsigned lim;
      int unsigned s;
      logic [CODE_W-1:0] code;
      call_t c;
      call_t batch[$];
      if (op_v == OP_LOAD) begin
        keep_mem[idx] = keep_v;
        row_mem[idx] = row_v;
        written[idx] = 1'b1;
        loads_seen++;
        return;
      end
      bytes_seen++;
      n = eff_samples();
      bpv = (n + 3) / 4;
      lim = (chunk_len == 0) ? 65536 : chunk_len;
      for (int k = 0; k < LANES; k++) begin
        s = byte_pos * 4 + k;
        if (s >= n) break;
        if (keep_mem[s]) begin
          code = b[2*k +: 2];
          c.column = 16'(col_ctr);
          c.row = row_mem[s];
          c.value = code_tbl[16*code +: 16];
          c.last = 1'b0;
          batch = {batch, c};
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      calls_due = {calls_due, batch};
      byte_pos++;
      if (byte_pos >= bpv) begin
        byte_pos = 0;
        col_ctr++;
        if (col_ctr >= lim) col_ctr = 0;
      end
    endfunction

    function void compare(string field, logic signed [31:0] expv, logic signed [31:0] act);
      if (act !== expv) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, act);
      end
    endfunction

    function void match_call(logic [COLUMN_W-1:0] c, logic [ROW_W-1:0] r,
                             logic signed [VALUE_W-1:0] v, logic l);
      call_t e;
      if (calls_due.size() == 0) begin
        errors++;
        $display({"%0t: unexpected result: expected none, ",
                  "actual column %0d row %0d value %0d last %0b"},
                 $time, c, r, v, l);
        return;
      end
      e = calls_due.pop_front();
      calls_matched++;
      compare("column", 32'(e.column), 32'(c));
      compare("row", 32'(e.row), 32'(r));
      compare("value", 32'(e.value), 32'(v));
      compare("last", 32'(e.last), 32'(l));
    endfunction

    function void close_out();
      if (calls_due.size() != 0) begin
        errors += calls_due.size();
        $display("%0t: %0d expected results never arrived", $time, calls_due.size());
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic [INDEX_W-1:0]        map_index;
  logic                      map_keep;
  logic [ROW_W-1:0]          map_row;
  logic [7:0]                data_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [COLUMN_W-1:0]       column;
  logic [ROW_W-1:0]          row;
  logic signed [VALUE_W-1:0] value;
  logic                      last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  call_board_t calls = new();
  int  cycles = 0;
  int  items_sent = 0;
  int  phases = 0;
  int  keep_pct = 70;
  bit  tight = 1'b0;
  bit  squeeze_req = 1'b0;

  packed_genotype_unpacker_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("FAIL packed_genotype_unpacker_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) calls.match_call(column, row, value, last);
      if (in_valid && !in_stall) calls.accept_item(op, map_index, map_keep, map_row, data_byte);
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int pick;
    int hold;
    out_stall <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze_req) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_LEN) @(negedge clk);
        squeeze_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          out_stall <= 1'b0;
          hold = $urandom_range(10, 40);
        end else if (pick < 9) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          hold = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(8, 25);
        end
        repeat (hold) @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic op_v, input logic [INDEX_W-1:0] idx, input logic keep_v,
                           input logic [ROW_W-1:0] row_v, input logic [7:0] b);
    int gap;
    int r;
    gap = 0;
    if (!tight) begin
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_v;
    map_index <= idx;
    map_keep  <= keep_v;
    map_row   <= row_v;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic keep_v,
                           input logic [ROW_W-1:0] row_v);
    send_item(OP_LOAD, idx, keep_v, row_v, 8'($urandom));
  endtask

  // load any sample of this byte that has no remap entry yet
  task automatic send_byte(input logic [7:0] b);
    int unsigned n;
    int unsigned s;
    n = calls.eff_samples();
    for (int k = 0; k < LANES; k++) begin
      s = calls.byte_pos * 4 + k;
      if (s < n && !calls.written[s])
        send_load(12'(s), $urandom_range(0, 99) < keep_pct, 12'($urandom));
    end
    send_item(OP_DATA, 12'($urandom), 1'($urandom), 12'($urandom), b);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    calls.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [SAMPLE_CNT_W-1:0] sc, input logic [COLUMN_W-1:0] cv,
                          input logic [CODE_TABLE_W-1:0] tbl);
    write_reg(REG_SAMPLE_COUNT, 64'(sc));
    write_reg(REG_CHUNK_VARIANTS, 64'(cv));
    write_reg(REG_CODE_TABLE, tbl);
    phases++;
  endtask

  // drop valid, wait for all results, then let silent bytes drain
  task automatic settle();
    in_valid <= 1'b0;
    while (calls.calls_due.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  initial begin
    int unsigned nbytes;
    logic [SAMPLE_CNT_W-1:0] sc;
    logic [COLUMN_W-1:0] cv;
    logic [CODE_TABLE_W-1:0] tbl;
    int p;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    op        <= OP_LOAD;
    map_index <= '0;
    map_keep  <= 1'b0;
    map_row   <= '0;
    data_byte <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SAMPLE_COUNT;
    cfg_data  <= '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // padded variant, extreme table values and rows, chunk wrap
    set_regs(13'd6, 16'd2, 64'h7FFF_8000_FFFF_0001);
    send_load(12'd0, 1'b1, 12'h000);
    send_load(12'd1, 1'b1, 12'hFFF);
    send_load(12'd2, 1'b0, 12'h555);
    send_load(12'd3, 1'b1, 12'hAAA);
    send_load(12'd4, 1'b1, 12'h007);
    send_load(12'd5, 1'b1, 12'hFFF);
    send_load(12'hFFF, 1'b1, 12'h800);
    send_byte(8'hE4);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h1B);
    send_byte(8'hA5);
    send_byte(8'h5A);
    settle();

    // zero sample count, bytes with nothing kept
    set_regs(13'd0, 16'd1, 64'h0100_0080_FF80_0000);
    send_load(12'd0, 1'b0, 12'h123);
    send_byte(8'hFF);
    send_byte(8'h03);
    send_load(12'd0, 1'b1, 12'h003);
    send_byte(8'h02);
    send_byte(8'h01);
    settle();

    // saturated sample count, left mid-variant for the next phase
    set_regs(13'h1FFF, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h6C);
    send_byte(8'h93);
    settle();

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      tight = ($urandom_range(0, 2) == 0);
      keep_pct = (p % 3 == 2) ? 20 : 75;
      sc = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(13, 40)) : 13'($urandom_range(1, 12));
      cv = 16'($urandom_range(1, 4));
      tbl = {$urandom, $urandom};
      nbytes = $urandom_range(10, 20);
      case (p)
        1: begin
          sc = 13'd8;
          keep_pct = 100;
          nbytes = 30;
        end
        2: tbl = 64'h8000_7FFF_0000_FFFF;
        3: begin
          sc = 13'd4096;
          nbytes = 4;
        end
        4: cv = 16'd0;
        5: cv = 16'hFFFF;
        default: ;
      endcase
      set_regs(sc, cv, tbl);
      if (p == 1) begin
        tight = 1'b1;
        squeeze_req = 1'b1;
      end
      repeat (nbytes) begin
        if ($urandom_range(0, 9) == 0)
          send_load(12'($urandom_range(0, 4095)), 1'($urandom), 12'($urandom));
        send_byte(8'($urandom_range(0, 255)));
      end
      p++;
    end
    settle();
    repeat (DRAIN) @(negedge clk);
    calls.close_out();

    $display("Run: %0d data bytes and %0d remap loads accepted, %0d results checked, %0d phases.",
             calls.bytes_seen, calls.loads_seen, calls.calls_matched, phases);
    $display({"Covered padding, zero and saturated sample counts, chunk wrap, ",
              "and a %0d-cycle hold-off."}, SQUEEZE_LEN);
    if (calls.errors == 0) begin
      $display("PASS packed_genotype_unpacker_unit");
    end else begin
      $display("FAIL packed_genotype_unpacker_unit");
    end
    $finish;
  end

endmodule
